[rtl/uerd_pkg.sv]
package uerd_pkg;

    // Default structural parameters.
    localparam int TIMER_BITS_DEF  = 8;
    localparam int DIGIT_COUNT_DEF = 4;

    // Field widths.
    localparam int RANGE_W     = 9;
    localparam int SEG_W       = 7;
    localparam int EN_W        = 4;
    localparam int DWELL_W     = 16;
    localparam int TRIG_W      = 8;
    localparam int PRESCALE_W  = 11;
    localparam int PRE_CNT_W   = 10;
    localparam int GAIN_W      = 9;
    localparam int GAIN_FRAC   = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int DIGIT_W     = 4;

    // Limits.
    localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = PRESCALE_W'(1024);
    localparam logic [RANGE_W-1:0]    RANGE_MAX    = RANGE_W'(511);

    // Register reset values.
    localparam logic [DWELL_W-1:0]    DWELL_RST    = DWELL_W'(2000);
    localparam logic [TRIG_W-1:0]     TRIG_RST     = TRIG_W'(10);
    localparam logic [PRESCALE_W-1:0] PRESCALE_RST = PRESCALE_W'(64);
    localparam logic [GAIN_W-1:0]     GAIN_RST     = GAIN_W'(281);

    // Constant division by reciprocal multiplication, exact for values below 512.
    localparam int DIV10_MUL    = 205;
    localparam int DIV10_SHIFT  = 11;
    localparam int DIV100_MUL   = 41;
    localparam int DIV100_SHIFT = 12;

    // Display digit positions.
    localparam int DIGIT_ONES     = 0;
    localparam int DIGIT_TENS     = 1;
    localparam int DIGIT_HUNDREDS = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DWELL    = 8'd0,
        CFG_TRIG     = 8'd1,
        CFG_PRESCALE = 8'd2,
        CFG_GAIN     = 8'd3
    } cfg_index_t;

    // Current configuration register values.
    typedef struct packed {
        logic [DWELL_W-1:0]    dwell_ticks;
        logic [TRIG_W-1:0]     trig_ticks;
        logic [PRESCALE_W-1:0] prescale_ticks;
        logic [GAIN_W-1:0]     range_gain;
    } cfg_t;

    // One result item, first field in the highest bits.
    typedef struct packed {
        logic [RANGE_W-1:0] range_value;
        logic [EN_W-1:0]    digit_enable_n;
        logic [SEG_W-1:0]   segments;
        logic               trig_out;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Seven-segment pattern of one decimal digit, segment a in bit 0.
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h67;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

[rtl/ultrasonic_echo_ranger_display_core.sv]
// The result of an input transaction is registered and waits on the master side in the next cycle.
// Throughput: one item per cycle; the result register frees each cycle it is taken.
// A result not yet taken stalls the slave side, so ready drops only under back-pressure.
// Reset (rst_n low, asynchronous) starts at the first display digit with all counters
// and the stored range at zero and the configuration registers at their defaults.
module ultrasonic_echo_ranger_display_core #(
    parameter int TIMER_BITS  = uerd_pkg::TIMER_BITS_DEF,
    parameter int DIGIT_COUNT = uerd_pkg::DIGIT_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [0] echo_level
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] trig_out, [7:1] segments, [11:8] digit_enable_n, [20:12] range_value
    output logic [uerd_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [uerd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [uerd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import uerd_pkg::*;

    cfg_t    cfg_reg;
    result_t result;
    result_t result_reg;
    logic    m_tvalid_reg;
    logic    in_accept;

    // The slave side moves whenever the result register is empty or being drained.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    uerd_seq #(
        .TIMER_BITS  (TIMER_BITS),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_accept),
        .echo_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .result     (result)
    );

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dwell_ticks    <= DWELL_RST;
            cfg_reg.trig_ticks     <= TRIG_RST;
            cfg_reg.prescale_ticks <= PRESCALE_RST;
            cfg_reg.range_gain     <= GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DWELL:    cfg_reg.dwell_ticks    <= cfg_data[DWELL_W-1:0];
                CFG_TRIG:     cfg_reg.trig_ticks     <= cfg_data[TRIG_W-1:0];
                CFG_PRESCALE: cfg_reg.prescale_ticks <= cfg_data[PRESCALE_W-1:0];
                CFG_GAIN:     cfg_reg.range_gain     <= cfg_data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Result register on the master side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(result_reg);

`ifndef NO_ASSERTIONS
    // At most one display digit is lit in any result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> $countones(~result_reg.digit_enable_n) <= 1)
    else $error("more than one digit enabled");

    // The trigger never fires while a digit is lit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && result_reg.trig_out |-> result_reg.digit_enable_n == '1)
    else $error("trigger overlaps a display digit");

    // Every input transaction leaves a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_tvalid_reg)
    else $error("accepted item produced no result");
`endif

endmodule

[rtl/uerd_digit.sv]
module uerd_digit #(
    parameter int PHASE_W = 3
) (
    input  logic [uerd_pkg::RANGE_W-1:0] value,
    input  logic [PHASE_W-1:0]           digit_sel,
    output logic [uerd_pkg::SEG_W-1:0]   pattern
);
    import uerd_pkg::*;

    localparam int Q10_PROD_W  = RANGE_W + 8;
    localparam int Q100_PROD_W = RANGE_W + 6;

    logic [Q10_PROD_W-1:0]  q10_prod;
    logic [Q100_PROD_W-1:0] q100_prod;
    logic [5:0]             q10;
    logic [2:0]             q100;
    logic [RANGE_W-1:0]     ones_full;
    logic [5:0]             tens_full;
    logic [DIGIT_W-1:0]     digit;

    // Split the range into decimal digits by reciprocal multiplication.
    always_comb
    begin
        q10_prod  = Q10_PROD_W'(value) * Q10_PROD_W'(DIV10_MUL);
        q100_prod = Q100_PROD_W'(value) * Q100_PROD_W'(DIV100_MUL);
        q10       = 6'(q10_prod >> DIV10_SHIFT);
        q100      = 3'(q100_prod >> DIV100_SHIFT);
        ones_full = value - RANGE_W'(q10) * RANGE_W'(10);
        tens_full = q10 - 6'(q100) * 6'd10;
    end

    // Pick the digit being shown; digits above hundreds are always zero.
    always_comb
    begin
        if (digit_sel == PHASE_W'(DIGIT_ONES))
        begin
            digit = DIGIT_W'(ones_full);
        end
        else if (digit_sel == PHASE_W'(DIGIT_TENS))
        begin
            digit = DIGIT_W'(tens_full);
        end
        else if (digit_sel == PHASE_W'(DIGIT_HUNDREDS))
        begin
            digit = DIGIT_W'(q100);
        end
        else
        begin
            digit = '0;
        end
        pattern = seg_pattern(digit);
    end

endmodule

[rtl/uerd_seq.sv]
module uerd_seq #(
    parameter int TIMER_BITS  = uerd_pkg::TIMER_BITS_DEF,
    parameter int DIGIT_COUNT = uerd_pkg::DIGIT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              echo_level,
    input  uerd_pkg::cfg_t    cfg,
    output uerd_pkg::result_t result
);
    import uerd_pkg::*;

    localparam int PHASE_W   = $clog2(DIGIT_COUNT + 3);
    localparam int EN_FULL_W = (DIGIT_COUNT > EN_W) ? DIGIT_COUNT : EN_W;
    localparam int PROD_W    = (TIMER_BITS + GAIN_W > 18) ? TIMER_BITS + GAIN_W : 18;
    localparam int SCALED_W  = PROD_W - GAIN_FRAC;

    localparam logic [PHASE_W-1:0] PH_FIRST = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_TRIG  = PHASE_W'(DIGIT_COUNT);
    localparam logic [PHASE_W-1:0] PH_RISE  = PHASE_W'(DIGIT_COUNT + 1);
    localparam logic [PHASE_W-1:0] PH_FALL  = PHASE_W'(DIGIT_COUNT + 2);

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [DWELL_W-1:0]    dwell_count_reg, dwell_count_next;
    logic [PRE_CNT_W-1:0]  prescale_count_reg, prescale_count_next;
    logic [TIMER_BITS-1:0] timer_count_reg, timer_count_next;
    logic [TIMER_BITS-1:0] rise_count_reg, rise_count_next;
    logic [RANGE_W-1:0]    range_reg, range_next;
    logic [SEG_W-1:0]      segment_latch_reg, segment_latch_next;

    logic [SEG_W-1:0]      digit_pat;
    logic [DWELL_W-1:0]    dwell_inc;
    logic [DWELL_W-1:0]    dwell_limit;
    logic [DWELL_W-1:0]    trig_limit;
    logic [PRESCALE_W-1:0] ps_limit;
    logic [PRESCALE_W-1:0] pre_inc;
    logic [TIMER_BITS-1:0] width;
    logic [PROD_W-1:0]     prod;
    logic [SCALED_W-1:0]   scaled;
    logic [RANGE_W-1:0]    new_range;
    logic [EN_FULL_W-1:0]  en_full;
    logic                  clear_timer;
    logic                  trig;

    // Segment pattern of the digit selected by the phase.
    uerd_digit #(
        .PHASE_W (PHASE_W)
    ) u_digit (
        .value     (range_reg),
        .digit_sel (phase_reg),
        .pattern   (digit_pat)
    );

    // Limits with zero treated as one and the prescaler saturated.
    always_comb
    begin
        dwell_inc   = dwell_count_reg + DWELL_W'(1);
        dwell_limit = (cfg.dwell_ticks == '0) ? DWELL_W'(1) : cfg.dwell_ticks;
        trig_limit  = (cfg.trig_ticks == '0) ? DWELL_W'(1) : DWELL_W'(cfg.trig_ticks);
        if (cfg.prescale_ticks == '0)
        begin
            ps_limit = PRESCALE_W'(1);
        end
        else if (cfg.prescale_ticks > PRESCALE_MAX)
        begin
            ps_limit = PRESCALE_MAX;
        end
        else
        begin
            ps_limit = cfg.prescale_ticks;
        end
    end

    // Scaled pulse width, saturated to the range field.
    always_comb
    begin
        width     = timer_count_reg - rise_count_reg;
        prod      = PROD_W'(width) * PROD_W'(cfg.range_gain);
        scaled    = prod[PROD_W-1:GAIN_FRAC];
        new_range = (|scaled[SCALED_W-1:RANGE_W]) ? RANGE_MAX : scaled[RANGE_W-1:0];
    end

    // Phase sequencer.
    always_comb
    begin
        phase_next         = phase_reg;
        dwell_count_next   = dwell_count_reg;
        rise_count_next    = rise_count_reg;
        range_next         = range_reg;
        segment_latch_next = segment_latch_reg;
        clear_timer        = 1'b0;
        trig               = 1'b0;
        if (phase_reg < PH_TRIG)
        begin
            segment_latch_next = digit_pat;
            if (dwell_inc >= dwell_limit)
            begin
                dwell_count_next = '0;
                phase_next       = phase_reg + PHASE_W'(1);
                clear_timer      = (phase_reg == PH_TRIG - PHASE_W'(1));
            end
            else
            begin
                dwell_count_next = dwell_inc;
            end
        end
        else if (phase_reg == PH_TRIG)
        begin
            trig = 1'b1;
            if (dwell_inc >= trig_limit)
            begin
                dwell_count_next = '0;
                phase_next       = PH_RISE;
            end
            else
            begin
                dwell_count_next = dwell_inc;
            end
        end
        else if (phase_reg == PH_RISE)
        begin
            if (echo_level)
            begin
                rise_count_next = timer_count_reg;
                phase_next      = PH_FALL;
            end
        end
        else
        begin
            if (!echo_level)
            begin
                if (timer_count_reg > rise_count_reg)
                begin
                    range_next = new_range;
                end
                phase_next       = PH_FIRST;
                dwell_count_next = '0;
            end
        end
    end

    // Free-running prescaler and echo timer; the timer restarts from zero on leaving the last digit.
    always_comb
    begin
        pre_inc = PRESCALE_W'(prescale_count_reg) + PRESCALE_W'(1);
        if (pre_inc >= ps_limit)
        begin
            prescale_count_next = '0;
            timer_count_next    = timer_count_reg + TIMER_BITS'(1);
        end
        else
        begin
            prescale_count_next = pre_inc[PRE_CNT_W-1:0];
            timer_count_next    = timer_count_reg;
        end
        if (clear_timer)
        begin
            timer_count_next = '0;
        end
    end

    // Active-low enable of the digit being shown.
    always_comb
    begin
        for (int i = 0; i < EN_FULL_W; i++)
        begin
            en_full[i] = (i < DIGIT_COUNT);
        end
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (phase_reg == PHASE_W'(DIGIT_COUNT - 1 - i))
            begin
                en_full[i] = 1'b0;
            end
        end
    end

    // Result of this tick.
    always_comb
    begin
        result.trig_out       = trig;
        result.segments       = segment_latch_next;
        result.digit_enable_n = en_full[EN_W-1:0];
        result.range_value    = range_next;
    end

    // Sequencer state advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_FIRST;
            dwell_count_reg    <= '0;
            prescale_count_reg <= '0;
            timer_count_reg    <= '0;
            rise_count_reg     <= '0;
            range_reg          <= '0;
            segment_latch_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            dwell_count_reg    <= dwell_count_next;
            prescale_count_reg <= prescale_count_next;
            timer_count_reg    <= timer_count_next;
            rise_count_reg     <= rise_count_next;
            range_reg          <= range_next;
            segment_latch_reg  <= segment_latch_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The range only changes on the tick that sees the echo fall.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(step && phase_reg == PH_FALL && !echo_level) |=> $stable(range_reg))
    else $error("range changed outside the echo fall");

    // Leaving the last digit restarts the echo timer.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_TRIG - PHASE_W'(1) && dwell_inc >= dwell_limit
        |=> timer_count_reg == '0 && phase_reg == PH_TRIG)
    else $error("timer not cleared when the trigger phase starts");

    // The sequencer holds still between transactions.
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(timer_count_reg) && $stable(dwell_count_reg))
    else $error("sequencer advanced without an input transaction");
`endif

endmodule
